>>> rtl/tlptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlptw_pkg
// Types and codes shared by the two-level page table walker and its channels.
// ----------------------------------------------------------------------------
package tlptw_pkg;

  localparam int VaWidth = 32;
  localparam int DescWidth = 32;
  localparam int ModeWidth = 5;
  localparam int StatusWidth = 3;
  localparam int DomainWidth = 4;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 32;
  localparam int TableBaseWidth = 18;
  localparam int ProtWidth = 2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_DESCRIPTOR = 1'b1;

  localparam logic RK_READ = 1'b0;
  localparam logic RK_FINAL = 1'b1;

  localparam logic [StatusWidth-1:0] ST_OK = 3'd0;
  localparam logic [StatusWidth-1:0] ST_SECTION_TRANS = 3'd1;
  localparam logic [StatusWidth-1:0] ST_PAGE_TRANS = 3'd2;
  localparam logic [StatusWidth-1:0] ST_SECTION_DOMAIN = 3'd3;
  localparam logic [StatusWidth-1:0] ST_PAGE_DOMAIN = 3'd4;
  localparam logic [StatusWidth-1:0] ST_SECTION_PERM = 3'd5;
  localparam logic [StatusWidth-1:0] ST_PAGE_PERM = 3'd6;
  localparam logic [StatusWidth-1:0] ST_FINE_UNSUPPORTED = 3'd7;

  localparam logic [CfgIndexWidth-1:0] REG_TABLE_BASE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DOMAIN_ACCESS = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_PROTECTION_BITS = 2'd2;

  localparam logic [1:0] DESC_FAULT = 2'd0;
  localparam logic [1:0] DESC_COARSE = 2'd1;
  localparam logic [1:0] DESC_SECTION = 2'd2;
  localparam logic [1:0] DESC_FINE = 2'd3;

  localparam logic [1:0] L2_LARGE = 2'd1;
  localparam logic [1:0] L2_SMALL = 2'd2;

  localparam logic [1:0] DOM_CLIENT = 2'd1;
  localparam logic [1:0] DOM_MANAGER = 2'd3;

  localparam logic [ModeWidth-1:0] MODE_USER = 5'b10000;

  typedef struct packed {
    logic                 opcode;
    logic [VaWidth-1:0]   virtual_address;
    logic [ModeWidth-1:0] processor_mode;
    logic                 is_write;
    logic [DescWidth-1:0] descriptor;
  } req_t;

  typedef struct packed {
    logic                   result_kind;
    logic [VaWidth-1:0]     address;
    logic [StatusWidth-1:0] status;
    logic [DomainWidth-1:0] fault_domain;
    logic                   cacheable;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/tlptw_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlptw_if
// Valid/ready channels for walker requests and walker results.
// ----------------------------------------------------------------------------
interface tlptw_req_if
  import tlptw_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tlptw_rsp_if
  import tlptw_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/two_level_page_table_walker_core.sv
// Each result is registered. Throughput: one item per cycle while the skid
// entry is empty; the walk state is updated at the transfer edge, so a
// descriptor may follow its read request in the next cycle.
// A two-entry output stage (result register plus skid) lets req take an
// item while a result waits. Items in the wrong phase are dropped silently.
// Reset (rst, synchronous) clears config, walk state and valid flags; walk to idle.
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_page_table_walker_core
// Two-level translation table walker with domain and permission checks.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_core
  import tlptw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  tlptw_req_if.sink                     req,
  tlptw_rsp_if.source                   rsp,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_L1   = 3'b010,
    PH_L2   = 3'b100
  } phase_t;

  logic [TableBaseWidth-1:0] table_base;
  logic [31:0]               domain_access;
  logic [ProtWidth-1:0]      protection_bits;

  phase_t                 phase, phase_next;
  logic [VaWidth-1:0]     held_vaddr, held_vaddr_next;
  logic                   held_user, held_user_next;
  logic                   held_write, held_write_next;
  logic [DomainWidth-1:0] held_domain, held_domain_next;

  logic rsp_valid;
  rsp_t rsp_data;
  logic skid_valid;
  rsp_t skid_data;

  logic accept, pop, produce;
  rsp_t result;

  req_t                   item;
  logic [DomainWidth-1:0] l1_dom;
  logic [1:0]             l1_class, l2_class, l2_sub, l2_ap;
  logic [StatusWidth-1:0] sec_status, page_status;
  logic                   page_cache;

  function automatic logic access_ok(input logic [1:0] ap, input logic user,
                                     input logic wr, input logic [1:0] prot);
    logic ok;
    if (user) begin
      case (ap)
        2'd0:    ok = (prot == 2'd2) && !wr;
        2'd1:    ok = 1'b0;
        2'd2:    ok = !wr;
        default: ok = 1'b1;
      endcase
    end else begin
      ok = (ap != 2'd0) || ((prot != 2'd0) && !wr);
    end
    return ok;
  endfunction

  function automatic logic [StatusWidth-1:0] check(
      input logic [1:0] cls, input logic ok,
      input logic [StatusWidth-1:0] dom_code, input logic [StatusWidth-1:0] perm_code);
    logic [StatusWidth-1:0] st;
    if (cls == DOM_MANAGER) begin
      st = ST_OK;
    end else if (cls == DOM_CLIENT) begin
      st = ok ? ST_OK : perm_code;
    end else begin
      st = dom_code;
    end
    return st;
  endfunction

  assign item = req.payload;
  assign pop = rsp_valid && rsp.ready;
  assign req.ready = !skid_valid;
  assign accept = req.valid && !skid_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.payload = rsp_data;

  assign l1_dom = item.descriptor[8:5];
  assign l1_class = domain_access[{l1_dom, 1'b0} +: 2];
  assign l2_class = domain_access[{held_domain, 1'b0} +: 2];
  assign l2_sub = (item.descriptor[1:0] == L2_LARGE) ? held_vaddr[15:14] : held_vaddr[11:10];
  assign l2_ap = item.descriptor[{l2_sub, 1'b0} + 5'd4 +: 2];
  assign sec_status = check(l1_class,
      access_ok(item.descriptor[11:10], held_user, held_write, protection_bits),
      ST_SECTION_DOMAIN, ST_SECTION_PERM);
  assign page_status = check(l2_class,
      access_ok(l2_ap, held_user, held_write, protection_bits),
      ST_PAGE_DOMAIN, ST_PAGE_PERM);
  assign page_cache = |item.descriptor[3:2];

  always_comb begin
    phase_next = phase;
    held_vaddr_next = held_vaddr;
    held_user_next = held_user;
    held_write_next = held_write;
    held_domain_next = held_domain;
    produce = 1'b0;
    result = '0;
    if (item.opcode == OP_TRANSLATE) begin
      if (phase == PH_IDLE) begin
        produce = 1'b1;
        phase_next = PH_L1;
        held_vaddr_next = item.virtual_address;
        held_user_next = (item.processor_mode == MODE_USER);
        held_write_next = item.is_write;
        result.result_kind = RK_READ;
        result.address = {table_base, item.virtual_address[31:20], 2'b00};
      end
    end else begin
      case (phase)
        PH_L1: begin
          produce = 1'b1;
          result.fault_domain = l1_dom;
          case (item.descriptor[1:0])
            DESC_COARSE: begin
              phase_next = PH_L2;
              held_domain_next = l1_dom;
              result.result_kind = RK_READ;
              result.address = {item.descriptor[31:10], held_vaddr[19:12], 2'b00};
            end
            DESC_SECTION: begin
              phase_next = PH_IDLE;
              result.result_kind = RK_FINAL;
              result.status = sec_status;
              result.cacheable = item.descriptor[3];
              if (sec_status == ST_OK) begin
                result.address = {item.descriptor[31:20], held_vaddr[19:0]};
              end
            end
            DESC_FINE: begin
              phase_next = PH_IDLE;
              result.result_kind = RK_FINAL;
              result.status = ST_FINE_UNSUPPORTED;
            end
            default: begin
              phase_next = PH_IDLE;
              result.result_kind = RK_FINAL;
              result.status = ST_SECTION_TRANS;
            end
          endcase
        end
        PH_L2: begin
          produce = 1'b1;
          phase_next = PH_IDLE;
          result.result_kind = RK_FINAL;
          result.fault_domain = held_domain;
          result.cacheable = page_cache;
          case (item.descriptor[1:0])
            L2_LARGE: begin
              result.status = page_status;
              if (page_status == ST_OK) begin
                result.address = {item.descriptor[31:16], held_vaddr[15:0]};
              end
            end
            L2_SMALL: begin
              result.status = page_status;
              if (page_status == ST_OK) begin
                result.address = {item.descriptor[31:12], held_vaddr[11:0]};
              end
            end
            default: begin
              result.status = ST_PAGE_TRANS;
            end
          endcase
        end
        default: begin
          produce = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
      domain_access <= '0;
      protection_bits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_BASE:      table_base <= cfg_data[TableBaseWidth-1:0];
        REG_DOMAIN_ACCESS:   domain_access <= cfg_data;
        REG_PROTECTION_BITS: protection_bits <= cfg_data[ProtWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held_vaddr <= '0;
      held_user <= 1'b0;
      held_write <= 1'b0;
      held_domain <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held_vaddr <= held_vaddr_next;
      held_user <= held_user_next;
      held_write <= held_write_next;
      held_domain <= held_domain_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        rsp_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept && produce) begin
      if (!rsp_valid || pop) begin
        rsp_data <= result;
        rsp_valid <= 1'b1;
      end else begin
        skid_data <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid entry held without a result in the output register");

  a_final_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && produce && result.result_kind == RK_FINAL) |=> (phase == PH_IDLE))
    else $error("final result did not return the walk to idle");

  a_read_status_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.result_kind == RK_READ) |-> (rsp_data.status == ST_OK))
    else $error("read request carries a fault status");

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.address == '0))
    else $error("fault result with nonzero address");
`endif

endmodule
`default_nettype wire
